/* sv/mpq_pkg.sv */
// Package for the multilevel priority queue: default sizes, field widths,
// operation and status codes, and the controller/datapath link types.
// No dependencies.
package mpq_pkg;

  // Default sizes, handed to the top level parameters
  localparam int NUM_LEVELS_DEF  = 4;
  localparam int LEVEL_DEPTH_DEF = 16;

  // Request and result field widths
  localparam int MODE_W   = 1;
  localparam int VALUE_W  = 32;
  localparam int LEVEL_W  = 2;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;      // request taken this cycle
    logic load_value;  // slot read data is valid, copy into result
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_read;   // pending request is a remove that hits a value
  } dp_sts_t;

endpackage

/* sv/mpq_if.sv */
// Channel interfaces for the multilevel priority queue: request and result.
// Depends on mpq_pkg.
interface mpq_in_if
  import mpq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic        [MODE_W-1:0]  mode;
  logic signed [VALUE_W-1:0] value;
  logic        [LEVEL_W-1:0] level;

  modport source (output valid, mode, value, level, input ready);
  modport sink   (input valid, mode, value, level, output ready);
endinterface

interface mpq_out_if
  import mpq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic signed [VALUE_W-1:0]  out_value;
  logic        [LEVEL_W-1:0]  out_level;

  modport source (output valid, status, out_value, out_level, input ready);
  modport sink   (input valid, status, out_value, out_level, output ready);
endinterface

/* sv/mpq_ctrl.sv */
// Controller for the multilevel priority queue: sequences one request
// through accept, slot read and result hand-off. Depends on mpq_pkg.
module mpq_ctrl
  import mpq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_OUT} state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  // Datapath commands
  assign cmd.accept     = in_valid & in_ready_r;
  assign cmd.load_value = (state_r == S_READ);

  // State and handshake registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_ready_r <= 1'b0;
            if (sts.need_read) begin
              state_r <= S_READ;
            end else begin
              state_r     <= S_OUT;
              out_valid_r <= 1'b1;
            end
          end
        end
        S_READ: begin
          state_r     <= S_OUT;
          out_valid_r <= 1'b1;
        end
        S_OUT: begin
          if (out_ready) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
          in_ready_r  <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* sv/mpq_dp.sv */
// Datapath for the multilevel priority queue: per-level pointers and counts,
// slot memory, priority pick and result registers. Depends on mpq_pkg.
module mpq_dp
  import mpq_pkg::*;
#(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_sts_t                    sts,
  input  logic        [MODE_W-1:0]   in_mode,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic        [LEVEL_W-1:0]  in_level,
  output logic        [STATUS_W-1:0] res_status,
  output logic signed [VALUE_W-1:0]  res_value,
  output logic        [LEVEL_W-1:0]  res_level
);

  localparam int LW    = $clog2(NUM_LEVELS);
  localparam int DW    = $clog2(LEVEL_DEPTH);
  localparam int CW    = $clog2(LEVEL_DEPTH + 1);
  localparam int AW    = LW + DW;
  localparam int SLOTS = 1 << AW;

  localparam logic [DW-1:0] PTR_LAST = DW'(LEVEL_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(LEVEL_DEPTH);

  logic [DW-1:0] head_r [NUM_LEVELS];
  logic [DW-1:0] tail_r [NUM_LEVELS];
  logic [CW-1:0] cnt_r  [NUM_LEVELS];

  logic [VALUE_W-1:0] slot_mem [SLOTS];
  logic [VALUE_W-1:0] rd_data_r;

  logic [STATUS_W-1:0] res_status_r;
  logic [VALUE_W-1:0]  res_value_r;
  logic [LEVEL_W-1:0]  res_level_r;

  logic          lvl_ok;
  logic [LW-1:0] ins_idx;
  logic          ins_full;
  logic          do_insert;
  logic          found;
  logic [LW-1:0] hit_idx;
  logic          do_remove;

  // Insert checks: level in range and not full
  assign lvl_ok   = (32'(in_level) < 32'(NUM_LEVELS));
  assign ins_idx  = LW'(in_level);
  assign ins_full = (cnt_r[ins_idx] == CNT_FULL);

  // Priority pick: highest-numbered non-empty level wins
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        found   = 1'b1;
        hit_idx = LW'(i);
      end
    end
  end

  assign do_insert     = cmd.accept && (in_mode == MODE_INSERT) && lvl_ok && !ins_full;
  assign do_remove     = cmd.accept && (in_mode == MODE_REMOVE) && found;
  assign sts.need_read = (in_mode == MODE_REMOVE) && found;

  // Pointer and count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (do_insert) begin
      tail_r[ins_idx] <= (tail_r[ins_idx] == PTR_LAST) ? '0 : tail_r[ins_idx] + DW'(1);
      cnt_r[ins_idx]  <= cnt_r[ins_idx] + CW'(1);
    end else if (do_remove) begin
      head_r[hit_idx] <= (head_r[hit_idx] == PTR_LAST) ? '0 : head_r[hit_idx] + DW'(1);
      cnt_r[hit_idx]  <= cnt_r[hit_idx] - CW'(1);
    end
  end

  // Slot memory: one write or one registered read per request
  always_ff @(posedge clk) begin
    if (do_insert) begin
      slot_mem[{ins_idx, tail_r[ins_idx]}] <= in_value;
    end
    if (do_remove) begin
      rd_data_r <= slot_mem[{hit_idx, head_r[hit_idx]}];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_value_r <= '0;
      res_level_r <= '0;
      if (in_mode == MODE_INSERT) begin
        res_status_r <= (lvl_ok && !ins_full) ? ST_DONE : ST_FULL;
      end else if (found) begin
        res_status_r <= ST_DONE;
        res_level_r  <= LEVEL_W'(hit_idx);
      end else begin
        res_status_r <= ST_EMPTY;
      end
    end else if (cmd.load_value) begin
      res_value_r <= rd_data_r;
    end
  end

  assign res_status = res_status_r;
  assign res_value  = res_value_r;
  assign res_level  = res_level_r;

endmodule

/* sv/multilevel_priority_queue.sv */
// Top level of the multilevel priority queue: controller plus datapath.
// Depends on mpq_pkg, mpq_if, mpq_ctrl and mpq_dp.
//
//   channel   dir  handshake          payload
//   in_if     in   valid / ready      mode, value, level
//   out_if    out  valid / ready      status, out_value, out_level
//
// One request at a time. An insert or a failed remove delivers its result
// the cycle after acceptance; a successful remove first passes through the
// slot-read state for the registered read of the slot memory.
// A stalled result holds; no request is taken until it is delivered.
// Reset (synchronous, active low) empties every level at once.
module multilevel_priority_queue
  import mpq_pkg::*;
#(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  mpq_in_if.sink  in_if,
  mpq_out_if.source out_if
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpq_dp #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_if.mode),
    .in_value   (in_if.value),
    .in_level   (in_if.level),
    .res_status (out_if.status),
    .res_value  (out_if.out_value),
    .res_level  (out_if.out_level)
  );

endmodule

/* sv/mpq_chk.sv */
// Port-level checks for the multilevel priority queue, bound to the top.
// Depends on mpq_pkg and multilevel_priority_queue.
module mpq_chk
  import mpq_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [VALUE_W-1:0]  out_value,
  input logic [LEVEL_W-1:0]  out_level
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(out_value) && $stable(out_level))
    else $error("result changed while stalled");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_DONE || status == ST_FULL || status == ST_EMPTY))
    else $error("undefined status code");

  // Failed requests carry zero value and level
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_DONE |-> out_value == '0 && out_level == '0)
    else $error("failed request with nonzero payload");

  // One request in flight: no second request until its result leaves
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is pending");

  // Reset clears the result side
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multilevel_priority_queue mpq_chk u_mpq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .status    (out_if.status),
  .out_value (out_if.out_value),
  .out_level (out_if.out_level)
);

/* tb/sv/multilevel_priority_queue_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for multilevel_priority_queue: directed and random
// inserts/removes checked against a per-level FIFO predictor of the queue.
// Depends on mpq_pkg, mpq_if and the multilevel_priority_queue RTL.
module multilevel_priority_queue_tb;
  import mpq_pkg::*;

  localparam int NUM_LEVELS  = NUM_LEVELS_DEF;
  localparam int LEVEL_DEPTH = LEVEL_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic        [STATUS_W-1:0] status;
    logic signed [VALUE_W-1:0]  value;
    logic        [LEVEL_W-1:0]  level;
  } pq_result_t;

  logic clk;
  logic rst_n;

  mpq_in_if  in_ch ();
  mpq_out_if out_ch ();

  multilevel_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Predictor state: one circular FIFO per level
  logic signed [VALUE_W-1:0] level_slots [NUM_LEVELS][LEVEL_DEPTH];
  int head_pos [NUM_LEVELS];
  int tail_pos [NUM_LEVELS];
  int fill_cnt [NUM_LEVELS];

  pq_result_t pending_results [$];

  int error_count = 0;
  int cycle_count = 0;
  bit tx_gaps_on  = 1'b1;
  bit rx_stalls_on = 1'b1;
  int rx_hold_cycles = 0;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("ERROR @%0t: %s: got %0h, expected %0h", $realtime, what, got, exp_val);
    error_count++;
  endtask

  // Apply one request to the predictor and queue the result it should produce
  task automatic predict_pq_result(input logic [MODE_W-1:0] mode,
                                   input logic signed [VALUE_W-1:0] value,
                                   input logic [LEVEL_W-1:0] level);
    pq_result_t res;
    int lv;
    res.status = ST_DONE;
    res.value  = '0;
    res.level  = '0;
    lv = int'(level);
    if (mode == MODE_INSERT) begin
      if (lv >= NUM_LEVELS || fill_cnt[lv] >= LEVEL_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        level_slots[lv][tail_pos[lv]] = value;
        tail_pos[lv] = (tail_pos[lv] + 1) % LEVEL_DEPTH;
        fill_cnt[lv]++;
      end
    end else begin
      // highest non-empty level wins
      lv = NUM_LEVELS - 1;
      while (lv >= 0 && fill_cnt[lv] == 0) lv--;
      if (lv < 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.value = level_slots[lv][head_pos[lv]];
        res.level = LEVEL_W'(lv);
        head_pos[lv] = (head_pos[lv] + 1) % LEVEL_DEPTH;
        fill_cnt[lv]--;
      end
    end
    pending_results.push_back(res);
  endtask

  // Offer one request; returns in the time step of its acceptance
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic signed [VALUE_W-1:0] value,
                              input logic [LEVEL_W-1:0] level);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.value <= value;
    in_ch.level <= level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_pq_result(mode, value, level);
  endtask

  // Drop valid and hold off until every queued result has been checked
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh8000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Result side: per-result stall, optional long hold, check at handshake
  initial begin
    pq_result_t exp_res;
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_stalls_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_ch.status), '0);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.status !== exp_res.status)
          report_mismatch("status", 32'(out_ch.status), 32'(exp_res.status));
        if (out_ch.out_value !== exp_res.value)
          report_mismatch("out_value", out_ch.out_value, exp_res.value);
        if (out_ch.out_level !== exp_res.level)
          report_mismatch("out_level", 32'(out_ch.out_level), 32'(exp_res.level));
      end
    end
  end

  // Remove from an empty queue
  task automatic test_empty_remove();
    send_request(MODE_REMOVE, pick_value(), LEVEL_W'($urandom_range(0, 3)));
  endtask

  // Extreme and zero values on every level, removed in priority order
  task automatic test_extremes_and_priority();
    send_request(MODE_INSERT, '0, 2'd0);
    send_request(MODE_INSERT, 32'sh7fff_ffff, 2'd1);
    send_request(MODE_INSERT, 32'sh8000_0000, 2'd3);
    send_request(MODE_INSERT, -32'sd1, 2'd2);
    repeat (5) send_request(MODE_REMOVE, pick_value(), 2'd3);
  endtask

  // Fill one level to the brim, then one insert too many
  task automatic test_level_full();
    repeat (LEVEL_DEPTH + 1) send_request(MODE_INSERT, pick_value(), 2'd1);
  endtask

  // Random mix; insert_pct biases toward filling or draining, a focus level
  // concentrates inserts so that a level runs full
  task automatic test_random_traffic(input int n_items, input int insert_pct,
                                     input bit use_focus);
    logic [LEVEL_W-1:0] focus_lv;
    logic [LEVEL_W-1:0] lv;
    focus_lv = LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
    repeat (n_items) begin
      lv = LEVEL_W'($urandom_range(0, 3));
      if (use_focus && $urandom_range(0, 3) != 0) lv = focus_lv;
      if ($urandom_range(0, 99) < insert_pct)
        send_request(MODE_INSERT, pick_value(), lv);
      else
        send_request(MODE_REMOVE, pick_value(), lv);
    end
  endtask

  // Long receiver hold while requests keep coming
  task automatic test_backpressure();
    rx_hold_cycles = 200;
    test_random_traffic(40, 60, 1'b0);
  endtask

  // Stimulus
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_INSERT;
    in_ch.value <= '0;
    in_ch.level <= '0;
    rst_n <= 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      head_pos[i] = 0;
      tail_pos[i] = 0;
      fill_cnt[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_remove();
    test_extremes_and_priority();
    test_level_full();

    test_random_traffic(400, 50, 1'b0);
    test_random_traffic(300, 80, 1'b1);
    test_random_traffic(300, 25, 1'b0);
    wait_for_drain();

    // stretch with no idling on either side
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    test_random_traffic(300, 55, 1'b1);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;

    test_backpressure();
    test_random_traffic(500, 50, 1'b1);

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
